[sv/mcpf_pkg.sv]
// Shared types, sizes and codes of the multi-channel pipe FIFO.
// Used by the pipe table, the top module and the testbench; depends on nothing.
`timescale 1ns / 1ps

package mcpf_pkg;

    // Sizing of the pipe set
    localparam int NUM_PIPES  = 8;
    localparam int PIPE_DEPTH = 256;
    localparam int WORD_BITS  = 16;

    localparam int PIPE_BITS  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PIPE_SLOTS = 2 ** PIPE_BITS;
    localparam int PTR_BITS   = $clog2(PIPE_DEPTH);
    localparam int CNT_BITS   = $clog2(PIPE_DEPTH + 1);
    localparam int SUM_BITS   = CNT_BITS + 1;
    localparam int ADDR_BITS  = PIPE_BITS + PTR_BITS;
    localparam int SEL_CMP_BITS = 8;

    // Fixed field widths
    localparam int KIND_BITS   = 3;
    localparam int SEL_BITS    = 3;
    localparam int DWORD_BITS  = 16;
    localparam int STATUS_BITS = 2;

    // Operation codes
    localparam logic [KIND_BITS-1:0] OP_ALLOC    = 3'd0;
    localparam logic [KIND_BITS-1:0] OP_WRITE    = 3'd1;
    localparam logic [KIND_BITS-1:0] OP_READ     = 3'd2;
    localparam logic [KIND_BITS-1:0] OP_CLOSE_RD = 3'd3;
    localparam logic [KIND_BITS-1:0] OP_CLOSE_WR = 3'd4;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_PIPE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd3;

    // Word store access issued by the pipe table
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

    // Per-item outcome handed to the result stage
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SEL_BITS-1:0]    index;
        logic                   rd_ok;
    } op_res_t;

endpackage

[sv/mcpf_word_ram.sv]
// Single-port word store with a registered read.
// Generic RAM; no package dependencies.
`timescale 1ns / 1ps

module mcpf_word_ram #(
    parameter int DATA_BITS = 16,
    parameter int ADDR_BITS = 11
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    // Write on request, register read data and hold it between reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/mcpf_pipe_ctrl.sv]
// Pipe table: pointers, fill counts and end flags of every pipe.
// Decides each operation and issues the word store access; uses mcpf_pkg.
`timescale 1ns / 1ps

module mcpf_pipe_ctrl
    import mcpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    input  logic [KIND_BITS-1:0]  kind,
    input  logic [SEL_BITS-1:0]   pipe_sel,
    input  logic [DWORD_BITS-1:0] word_in,
    output mem_req_t              mem_req,
    output op_res_t               op_res
);

    logic [PTR_BITS-1:0] rp_reg      [PIPE_SLOTS];
    logic [CNT_BITS-1:0] fill_reg    [PIPE_SLOTS];
    logic [PIPE_SLOTS-1:0] in_use_reg;
    logic [PIPE_SLOTS-1:0] rd_open_reg;
    logic [PIPE_SLOTS-1:0] wr_open_reg;

    logic                  sel_ok;
    logic [PIPE_BITS-1:0]  sel_idx;
    logic [PTR_BITS-1:0]   cur_rp;
    logic [CNT_BITS-1:0]   cur_fill;
    logic                  cur_rd_open;
    logic                  cur_wr_open;
    logic                  free_found;
    logic [PIPE_BITS-1:0]  free_idx;
    logic [SUM_BITS-1:0]   pos_sum;
    logic [PTR_BITS-1:0]   wr_pos;
    logic [PTR_BITS-1:0]   rp_inc;
    logic                  do_alloc;
    logic                  do_write;
    logic                  do_read;
    logic                  do_close_rd;
    logic                  do_close_wr;

    // Look up the addressed pipe
    assign sel_ok      = SEL_CMP_BITS'(pipe_sel) < SEL_CMP_BITS'(NUM_PIPES);
    assign sel_idx     = PIPE_BITS'(pipe_sel);
    assign cur_rp      = rp_reg[sel_idx];
    assign cur_fill    = fill_reg[sel_idx];
    assign cur_rd_open = sel_ok & rd_open_reg[sel_idx];
    assign cur_wr_open = sel_ok & wr_open_reg[sel_idx];

    // Find the lowest free pipe
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int p = NUM_PIPES - 1; p >= 0; p--) begin
            if (!in_use_reg[p]) begin
                free_found = 1'b1;
                free_idx   = PIPE_BITS'(p);
            end
        end
    end

    // Ring positions: write slot is read pointer plus fill, wrapped once
    assign pos_sum = SUM_BITS'(cur_rp) + SUM_BITS'(cur_fill);
    assign wr_pos  = (pos_sum >= SUM_BITS'(PIPE_DEPTH))
                   ? PTR_BITS'(pos_sum - SUM_BITS'(PIPE_DEPTH))
                   : PTR_BITS'(pos_sum);
    assign rp_inc  = (cur_rp == PTR_BITS'(PIPE_DEPTH - 1)) ? '0 : cur_rp + PTR_BITS'(1);

    // Decide the operation
    always_comb begin
        do_alloc       = 1'b0;
        do_write       = 1'b0;
        do_read        = 1'b0;
        do_close_rd    = 1'b0;
        do_close_wr    = 1'b0;
        op_res.status  = ST_OK;
        op_res.index   = pipe_sel;
        op_res.rd_ok   = 1'b0;
        case (kind)
            OP_ALLOC: begin
                op_res.index = free_found ? SEL_BITS'(free_idx) : '0;
                if (free_found) begin
                    do_alloc = op_valid;
                end else begin
                    op_res.status = ST_NO_PIPE;
                end
            end
            OP_WRITE: begin
                if (!cur_wr_open || cur_fill >= CNT_BITS'(PIPE_DEPTH)) begin
                    op_res.status = ST_FULL;
                end else begin
                    do_write = op_valid;
                end
            end
            OP_READ: begin
                if (!cur_rd_open || cur_fill == '0) begin
                    op_res.status = ST_EMPTY;
                end else begin
                    do_read      = op_valid;
                    op_res.rd_ok = 1'b1;
                end
            end
            OP_CLOSE_RD: begin
                do_close_rd = op_valid & cur_rd_open;
            end
            OP_CLOSE_WR: begin
                do_close_wr = op_valid & cur_wr_open;
            end
            default: begin
                op_res.status = ST_OK;
            end
        endcase
    end

    // Word store access for the addressed pipe
    assign mem_req.wr_en = do_write;
    assign mem_req.rd_en = do_read;
    assign mem_req.addr  = do_write ? {sel_idx, wr_pos} : {sel_idx, cur_rp};
    assign mem_req.wdata = WORD_BITS'(word_in);

    // Update the pipe table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PIPE_SLOTS; p++) begin
                rp_reg[p]   <= '0;
                fill_reg[p] <= '0;
            end
            in_use_reg  <= '0;
            rd_open_reg <= '0;
            wr_open_reg <= '0;
        end else begin
            if (do_alloc) begin
                rp_reg[free_idx]      <= '0;
                fill_reg[free_idx]    <= '0;
                in_use_reg[free_idx]  <= 1'b1;
                rd_open_reg[free_idx] <= 1'b1;
                wr_open_reg[free_idx] <= 1'b1;
            end
            if (do_write) begin
                fill_reg[sel_idx] <= cur_fill + CNT_BITS'(1);
            end
            if (do_read) begin
                rp_reg[sel_idx]   <= rp_inc;
                fill_reg[sel_idx] <= cur_fill - CNT_BITS'(1);
            end
            // Release the pipe once both ends are closed
            if (do_close_rd) begin
                rd_open_reg[sel_idx] <= 1'b0;
                if (!cur_wr_open) begin
                    in_use_reg[sel_idx] <= 1'b0;
                end
            end
            if (do_close_wr) begin
                wr_open_reg[sel_idx] <= 1'b0;
                if (!cur_rd_open) begin
                    in_use_reg[sel_idx] <= 1'b0;
                end
            end
        end
    end

endmodule

[sv/multi_channel_pipe_fifo_top.sv]
// Multi-channel pipe FIFO: pipes sharing one word store. One item is taken per cycle
// unless the result channel stalls, set by the single word store port (pipe table
// update and store read issued at accept, then the output register). Reset clears the
// pipe table (all pipes free, ends closed); the word store is not cleared and needs no
// clearing pass.
// Depends on mcpf_pkg, mcpf_pipe_ctrl and mcpf_word_ram.
`timescale 1ns / 1ps

module multi_channel_pipe_fifo_top
    import mcpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // kind[2:0], pipe_sel[5:3], word_in[21:6], zero[23:22]
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], pipe_index[4:2], word_out[20:5], zero[23:21]
    output logic        m_tlast    // end_of_transfer
);

    logic                  s_xfer;
    logic                  s1_advance;
    mem_req_t              mem_req;
    op_res_t               op_res;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  s1_valid_reg;
    op_res_t               s1_res_reg;
    logic                  s1_last_reg;

    logic                  m_valid_reg;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic [SEL_BITS-1:0]   m_index_reg;
    logic [DWORD_BITS-1:0] m_word_reg;
    logic                  m_last_reg;

    // Handshake: stage one moves on when the output register is free or drains
    assign s1_advance = s1_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready   = ~s1_valid_reg | s1_advance;
    assign s_xfer     = s_tvalid & s_tready;

    mcpf_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (s_xfer),
        .kind     (s_tdata[2:0]),
        .pipe_sel (s_tdata[5:3]),
        .word_in  (s_tdata[21:6]),
        .mem_req  (mem_req),
        .op_res   (op_res)
    );

    mcpf_word_ram #(
        .DATA_BITS (WORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .aclk  (aclk),
        .wr_en (mem_req.wr_en),
        .rd_en (mem_req.rd_en),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    // Stage one: hold the outcome while the store read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_res_reg  <= op_res;
            s1_last_reg <= s_tlast;
        end
    end

    // Output register: load on advance, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_status_reg <= s1_res_reg.status;
            m_index_reg  <= s1_res_reg.index;
            m_word_reg   <= s1_res_reg.rd_ok ? DWORD_BITS'(ram_rdata) : '0;
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_word_reg, m_index_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule

[sim/pipe_fifo_checker.sv]
// Checker for the multi-channel pipe FIFO: follows both stream channels, predicts each result
// from its own copy of the pipe table and word store, and compares field by field.
// Depends on mcpf_pkg.
`timescale 1ns / 1ps

module pipe_fifo_checker
    import mcpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // kind[2:0], pipe_sel[5:3], word_in[21:6], zero[23:22]
    input  logic        s_tlast,   // last_word
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // status[1:0], pipe_index[4:2], word_out[20:5], zero[23:21]
    input  logic        m_tlast,   // end_of_transfer
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          words_read,
    output int          full_refusals,
    output int          empty_refusals,
    output int          alloc_refusals
);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SEL_BITS-1:0]    pipe_index;
        logic [DWORD_BITS-1:0]  word_out;
        logic                   eot;
        logic [2:0]             pad;
    } pipe_result_t;

    // Shadow pipe table and word store
    logic [WORD_BITS-1:0] word_store [NUM_PIPES*PIPE_DEPTH];
    int                   read_ptr   [NUM_PIPES];
    int                   fill_cnt   [NUM_PIPES];
    logic                 in_use     [NUM_PIPES];
    logic                 rd_open    [NUM_PIPES];
    logic                 wr_open    [NUM_PIPES];

    pipe_result_t expected_results [$];
    pipe_result_t got, want;

    initial begin
        fail_count     = 0;
        pending        = 0;
        results_seen   = 0;
        words_read     = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        alloc_refusals = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got_val, input int want_val);
        if (got_val != want_val)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got_val, want_val));
    endtask

    task automatic clear_pipe_table();
        for (int p = 0; p < NUM_PIPES; p++) begin
            read_ptr[p] = 0;
            fill_cnt[p] = 0;
            in_use[p]   = 1'b0;
            rd_open[p]  = 1'b0;
            wr_open[p]  = 1'b0;
        end
    endtask

    // Apply one operation to the shadow state and return the result it gives
    task automatic apply_pipe_op(input logic [KIND_BITS-1:0] kind,
                                 input logic [SEL_BITS-1:0] sel,
                                 input logic [DWORD_BITS-1:0] word,
                                 input logic last,
                                 output pipe_result_t res);
        int  p;
        int  slot;
        bit  valid;
        p     = int'(sel);
        valid = (p < NUM_PIPES);
        res.status     = ST_OK;
        res.pipe_index = sel;
        res.word_out   = '0;
        res.eot        = last;
        res.pad        = '0;
        case (kind)
            OP_ALLOC: begin
                res.pipe_index = '0;
                res.status     = ST_NO_PIPE;
                for (int q = 0; q < NUM_PIPES; q++) begin
                    if (!in_use[q]) begin
                        in_use[q]      = 1'b1;
                        read_ptr[q]    = 0;
                        fill_cnt[q]    = 0;
                        rd_open[q]     = 1'b1;
                        wr_open[q]     = 1'b1;
                        res.pipe_index = SEL_BITS'(q);
                        res.status     = ST_OK;
                        break;
                    end
                end
            end
            OP_WRITE: begin
                if (!valid || !wr_open[p] || fill_cnt[p] >= PIPE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = p * PIPE_DEPTH + (read_ptr[p] + fill_cnt[p]) % PIPE_DEPTH;
                    word_store[slot] = WORD_BITS'(word);
                    fill_cnt[p]++;
                end
            end
            OP_READ: begin
                if (!valid || !rd_open[p] || fill_cnt[p] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = p * PIPE_DEPTH + read_ptr[p];
                    res.word_out = DWORD_BITS'(word_store[slot]);
                    read_ptr[p]  = (read_ptr[p] + 1) % PIPE_DEPTH;
                    fill_cnt[p]--;
                end
            end
            OP_CLOSE_RD: begin
                if (valid && rd_open[p]) begin
                    rd_open[p] = 1'b0;
                    if (!wr_open[p]) in_use[p] = 1'b0;
                end
            end
            OP_CLOSE_WR: begin
                if (valid && wr_open[p]) begin
                    wr_open[p] = 1'b0;
                    if (!rd_open[p]) in_use[p] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // Predict on every input transfer, compare on every result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_pipe_table();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                apply_pipe_op(s_tdata[2:0], s_tdata[5:3], s_tdata[21:6], s_tlast, want);
                expected_results.push_back(want);
                // Count successful reads; their words are the deepest check
                if (s_tdata[2:0] == OP_READ && want.status == ST_OK)
                    words_read++;
            end
            if (m_tvalid && m_tready) begin
                got.status     = m_tdata[1:0];
                got.pipe_index = m_tdata[4:2];
                got.word_out   = m_tdata[20:5];
                got.eot        = m_tlast;
                got.pad        = m_tdata[23:21];
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing expected, tdata 0x%06h",
                                              m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", got.status, want.status);
                    check_field("pipe_index", got.pipe_index, want.pipe_index);
                    check_field("word_out", got.word_out, want.word_out);
                    check_field("end_of_transfer", got.eot, want.eot);
                    check_field("tdata padding", got.pad, want.pad);
                    case (want.status)
                        ST_FULL:    full_refusals++;
                        ST_EMPTY:   empty_refusals++;
                        ST_NO_PIPE: alloc_refusals++;
                        default:    ;
                    endcase
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

[sim/tb_top.sv]
// Top of the pipe FIFO testbench: clock, reset, stimulus and verdict.
// Depends on mcpf_pkg, multi_channel_pipe_fifo_top and pipe_fifo_checker.
`timescale 1ns / 1ps

module tb_top;
    import mcpf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MIX_ITEMS    = 100;
    localparam int WRAP_ITEMS   = 20;

    // Kind codes the block treats as no operation
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;
    localparam logic [SEL_BITS-1:0]  FILL_PIPE     = 3'd0;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_PERIODIC, RDY_COIN} ready_mode_e;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // kind[2:0], pipe_sel[5:3], word_in[21:6], zero[23:22]
    logic        s_tlast  = 1'b0; // last_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // status[1:0], pipe_index[4:2], word_out[20:5], zero[23:21]
    logic        m_tlast;         // end_of_transfer

    int fail_count, pending, results_seen, words_read;
    int full_refusals, empty_refusals, alloc_refusals;
    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    ready_mode_e ready_mode = RDY_ALWAYS;

    multi_channel_pipe_fifo_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pipe_fifo_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .words_read     (words_read),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals),
        .alloc_refusals (alloc_refusals)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Stall the result channel with a randomly chosen ready pattern
    always @(posedge aclk) begin
        if (cycle_count % 64 == 0)
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS:   m_tready <= 1'b1;
                RDY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                RDY_PERIODIC: m_tready <= (cycle_count % 7 >= 3);
                default:      m_tready <= 1'($urandom);
            endcase
        end
    end

    // Offer one item; idle between bursts of random length
    task automatic send_item(input logic [KIND_BITS-1:0] kind,
                             input logic [SEL_BITS-1:0] sel,
                             input logic [DWORD_BITS-1:0] word,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, word, sel, kind};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // Hold the input channel until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic send_random(input logic [KIND_BITS-1:0] kind, input logic [SEL_BITS-1:0] sel);
        send_item(kind, sel, DWORD_BITS'($urandom), 1'($urandom));
    endtask

    // Extremes, every operation and the refusal cases
    task automatic run_directed();
        send_item(OP_WRITE, 3'd3, 16'h1234, 1'b0);       // write to a free pipe
        send_item(OP_READ, 3'd3, 16'h0000, 1'b1);        // read from a free pipe
        for (int i = 0; i < NUM_PIPES; i++)
            send_random(OP_ALLOC, SEL_BITS'(i));
        send_item(OP_ALLOC, 3'd7, 16'hFFFF, 1'b1);       // no free pipe left
        send_item(OP_WRITE, 3'd7, 16'hFFFF, 1'b1);
        send_item(OP_WRITE, 3'd7, 16'h0000, 1'b0);
        send_item(OP_CLOSE_RD, 3'd7, 16'h0000, 1'b0);
        send_item(OP_READ, 3'd7, 16'h0000, 1'b0);        // read end closed, words remain
        send_item(OP_CLOSE_RD, 3'd7, 16'hFFFF, 1'b1);    // second close has no effect
        send_item(OP_CLOSE_WR, 3'd7, 16'h0000, 1'b0);    // both ends closed: pipe freed
        send_item(OP_WRITE, 3'd7, 16'hA5A5, 1'b1);
        send_item(OP_ALLOC, 3'd0, 16'h0000, 1'b0);       // regrants pipe 7
        send_item(OP_READ, 3'd7, 16'h0000, 1'b1);        // fresh pipe is empty
        send_item(OP_WRITE, 3'd6, 16'hFFFF, 1'b0);
        send_item(OP_CLOSE_WR, 3'd6, 16'h0000, 1'b0);
        send_item(OP_CLOSE_WR, 3'd6, 16'h0000, 1'b1);
        send_item(OP_WRITE, 3'd6, 16'h5A5A, 1'b0);       // write end closed
        send_item(OP_READ, 3'd6, 16'h0000, 1'b0);        // read still drains
        send_item(KIND_SPARE_LO, 3'd2, 16'hABCD, 1'b0);
        send_item(KIND_SPARE_HI, 3'd7, 16'hFFFF, 1'b1);
    endtask

    // Free every pipe, take pipe 0, fill it past full, wrap the ring and drain past empty
    task automatic run_fill_cycle();
        for (int i = 0; i < NUM_PIPES; i++) begin
            send_random(OP_CLOSE_RD, SEL_BITS'(i));
            send_random(OP_CLOSE_WR, SEL_BITS'(i));
        end
        send_random(OP_ALLOC, SEL_BITS'($urandom));
        repeat (PIPE_DEPTH + 1) send_random(OP_WRITE, FILL_PIPE);
        repeat (WRAP_ITEMS) send_random(OP_READ, FILL_PIPE);
        repeat (WRAP_ITEMS) send_random(OP_WRITE, FILL_PIPE);
        repeat (PIPE_DEPTH + 1) send_random(OP_READ, FILL_PIPE);
    endtask

    // Mixed traffic, mostly aimed at one pipe at a time
    task automatic run_mixed();
        int pick;
        logic [SEL_BITS-1:0] focus;
        logic [SEL_BITS-1:0] sel;
        logic [KIND_BITS-1:0] kind;
        focus = SEL_BITS'($urandom);
        for (int i = 0; i < MIX_ITEMS; i++) begin
            if ($urandom_range(0, 15) == 0) focus = SEL_BITS'($urandom);
            sel  = ($urandom_range(0, 4) == 0) ? SEL_BITS'($urandom) : focus;
            pick = $urandom_range(0, 99);
            if (pick < 8)       kind = OP_ALLOC;
            else if (pick < 50) kind = OP_WRITE;
            else if (pick < 86) kind = OP_READ;
            else if (pick < 91) kind = OP_CLOSE_RD;
            else if (pick < 96) kind = OP_CLOSE_WR;
            else                kind = KIND_SPARE_LO + KIND_BITS'($urandom_range(0, 2));
            send_random(kind, sel);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_drained();
        run_fill_cycle();
        wait_drained();
        run_mixed();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items, checked %0d results, %0d words read back;", items_sent,
                 results_seen, words_read);
        $display("one pipe filled past full and wrapped. Refusals: %0d full, %0d empty, %0d alloc",
                 full_refusals, empty_refusals, alloc_refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule
